### rtl/core/mdv_pkg.sv
// mdv_pkg: parse phase codes, descriptor byte constants and the grammar
// transition function for the method descriptor validator
// no dependencies
`default_nettype none

package mdv_pkg;

    // parse phase encoding
    typedef logic [2:0] phase_t;

    localparam phase_t PH_START      = 3'd0;  // no byte of the string seen yet
    localparam phase_t PH_PARAM      = 3'd1;  // parameter type or ')' expected
    localparam phase_t PH_PARAM_ELEM = 3'd2;  // after '[' in a parameter
    localparam phase_t PH_PARAM_NAME = 3'd3;  // inside a parameter class name
    localparam phase_t PH_TAIL       = 3'd4;  // return or field type expected
    localparam phase_t PH_TAIL_NAME  = 3'd5;  // inside the final class name
    localparam phase_t PH_DONE       = 3'd6;  // final type complete
    localparam phase_t PH_ERROR      = 3'd7;  // string rejected

    // descriptor characters
    localparam logic [7:0] CH_LPAREN = 8'h28;  // (
    localparam logic [7:0] CH_RPAREN = 8'h29;  // )
    localparam logic [7:0] CH_SEMI   = 8'h3B;  // ;
    localparam logic [7:0] CH_LBRACK = 8'h5B;  // [
    localparam logic [7:0] CH_CLASS  = 8'h4C;  // L
    localparam logic [7:0] CH_DOT    = 8'h2E;  // .
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_J = 8'h4A;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_Z = 8'h5A;
    localparam logic [7:0] CH_V = 8'h56;

    // primitive type letter, void included
    function automatic logic is_base_letter(input logic [7:0] c);
        is_base_letter = (c == CH_B) || (c == CH_C) || (c == CH_D) || (c == CH_F) ||
                         (c == CH_I) || (c == CH_J) || (c == CH_S) || (c == CH_Z) ||
                         (c == CH_V);
    endfunction

    // byte inside a class name
    function automatic phase_t name_step(input logic [7:0] c, input phase_t name_ph,
                                         input phase_t done_ph);
        priority if (c == CH_SEMI) begin
            name_step = done_ph;
        end else if (c == CH_NUL || c == CH_DOT || c == CH_LBRACK) begin
            name_step = PH_ERROR;
        end else begin
            name_step = name_ph;
        end
    endfunction

    // first byte of a type, or byte after '['
    function automatic phase_t type_step(input logic [7:0] c, input phase_t arr_ph,
                                         input phase_t name_ph, input phase_t done_ph);
        priority if (c == CH_LBRACK) begin
            type_step = arr_ph;
        end else if (c == CH_CLASS) begin
            type_step = name_ph;
        end else if (is_base_letter(c)) begin
            type_step = done_ph;
        end else begin
            type_step = PH_ERROR;
        end
    endfunction

    // grammar transition for one byte
    function automatic phase_t next_phase(input phase_t ph, input logic [7:0] c);
        unique case (ph)
            PH_START: begin
                if (c == CH_LPAREN) begin
                    next_phase = PH_PARAM;
                end else begin
                    next_phase = type_step(c, PH_TAIL, PH_TAIL_NAME, PH_DONE);
                end
            end
            PH_PARAM: begin
                if (c == CH_RPAREN) begin
                    next_phase = PH_TAIL;
                end else begin
                    next_phase = type_step(c, PH_PARAM_ELEM, PH_PARAM_NAME, PH_PARAM);
                end
            end
            PH_PARAM_ELEM: next_phase = type_step(c, PH_PARAM_ELEM, PH_PARAM_NAME, PH_PARAM);
            PH_PARAM_NAME: next_phase = name_step(c, PH_PARAM_NAME, PH_PARAM);
            PH_TAIL:       next_phase = type_step(c, PH_TAIL, PH_TAIL_NAME, PH_DONE);
            PH_TAIL_NAME:  next_phase = name_step(c, PH_TAIL_NAME, PH_DONE);
            default:       next_phase = PH_ERROR;
        endcase
    endfunction

endpackage

`default_nettype wire

### rtl/core/method_descriptor_validator_top.sv
// method_descriptor_validator_top: byte-serial descriptor checker with
// input register, one-step grammar logic and a result register
// depends on mdv_pkg
//
// Usage:
//   s_ channel: one descriptor byte per beat on s_tdata[7:0]; s_tlast marks
//   the final byte of a string. Strings follow each other with no gap.
//   m_ channel: one beat per string, issued for the final byte only.
//   m_tdata[0] = valid_res (well formed descriptor), m_tdata[1] = method_kind.
// Timing:
//   one byte per cycle sustained while no final byte stalls. A byte waits in
//   the input register, where the grammar step against the phase register
//   runs; a final byte's verdict then goes to the result register, m_tvalid.
//   The only loop is the grammar step: one phase update per unstalled cycle.
// Stall:
//   non-final bytes never wait on the m_ side. A final byte waits in the
//   input register while an earlier verdict is still unread, and s_tready
//   then drops until m_tready frees the result register.
// Reset:
//   aresetn low clears both registers' valid flags and returns the parser to
//   the start of a string with the method flag cleared.
`default_nettype none

module method_descriptor_validator_top
    import mdv_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input byte stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] sig_byte
    input  wire logic       s_tlast,   // last
    // verdict stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] valid_res, [1] method_kind, [7:2] zero
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parser state
    phase_t     phase_reg, phase_next;
    logic       flag_reg, flag_next;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic       res_valid_reg;
    logic       res_method_reg;

    logic       out_free;
    logic       in_fire;
    logic       s_fire;
    phase_t     step_phase;
    logic       step_flag;

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign in_fire  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || in_fire;
    assign s_fire   = s_tvalid && s_tready;

    // grammar step for the registered byte
    always_comb begin
        step_phase = next_phase(phase_reg, in_byte_reg);
        step_flag  = flag_reg || (phase_reg == PH_START && in_byte_reg == CH_LPAREN);
    end

    // next state
    always_comb begin
        phase_next     = phase_reg;
        flag_next      = flag_reg;
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (in_fire) begin
            in_valid_next = 1'b0;
        end
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (in_fire) begin
            if (in_last_reg) begin
                phase_next     = PH_START;
                flag_next      = 1'b0;
                out_valid_next = 1'b1;
            end else begin
                phase_next = step_phase;
                flag_next  = step_flag;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_START;
            flag_reg      <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            flag_reg      <= flag_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (in_fire && in_last_reg) begin
            res_valid_reg  <= (step_phase == PH_DONE);
            res_method_reg <= step_flag;
        end
    end

    // outputs
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, res_method_reg, res_valid_reg};

    // checks
    a_reset_start: assert property (@(posedge aclk)
        !aresetn |=> (phase_reg == PH_START && !flag_reg && !out_valid_reg))
        else $error("parser not at start after reset");

    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_last_reg) |=> (out_valid_reg && phase_reg == PH_START && !flag_reg))
        else $error("final byte did not produce a verdict and restart");

    a_flag_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        flag_reg |-> (phase_reg != PH_START))
        else $error("method flag set at start of string");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_fire) |-> (in_last_reg && out_valid_reg && !m_tready))
        else $error("input register stalled without a blocked verdict");

endmodule

`default_nettype wire

### tb/sv/descriptor_verdict_checker.sv
`timescale 1ns / 1ps
// descriptor_verdict_checker: watches the byte and verdict streams of the
// descriptor validator, predicts each verdict and compares it beat by beat
// depends on mdv_pkg for the phase type and the descriptor characters

module descriptor_verdict_checker
    import mdv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] sig_byte
    input  logic       s_tlast,   // last
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [0] valid_res, [1] method_kind, [7:2] zero
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic valid_res;
        logic method_kind;
    } verdict_t;

    phase_t   grammar_ph;
    logic     opened_paren;
    verdict_t verdict_q[$];

    initial begin
        fail_count   = 0;
        pending      = 0;
        grammar_ph   = PH_START;
        opened_paren = 1'b0;
    end

    // primitive letters, void counted as one
    function automatic logic prim_letter(input logic [7:0] ch);
        case (ch)
            CH_B, CH_C, CH_D, CH_F, CH_I, CH_J, CH_S, CH_Z, CH_V: prim_letter = 1'b1;
            default: prim_letter = 1'b0;
        endcase
    endfunction

    // grammar position after one more byte of the string
    function automatic phase_t step_phase(input phase_t ph, input logic [7:0] ch);
        logic   in_params;
        phase_t arr_ph;
        phase_t cls_ph;
        phase_t end_ph;
        in_params  = (ph == PH_PARAM) || (ph == PH_PARAM_ELEM) || (ph == PH_PARAM_NAME);
        arr_ph     = in_params ? PH_PARAM_ELEM : PH_TAIL;
        cls_ph     = in_params ? PH_PARAM_NAME : PH_TAIL_NAME;
        end_ph     = in_params ? PH_PARAM : PH_DONE;
        step_phase = PH_ERROR;
        case (ph)
            PH_START, PH_PARAM, PH_PARAM_ELEM, PH_TAIL: begin
                if (ph == PH_START && ch == CH_LPAREN) begin
                    step_phase = PH_PARAM;
                end else if (ph == PH_PARAM && ch == CH_RPAREN) begin
                    step_phase = PH_TAIL;
                end else if (ch == CH_LBRACK) begin
                    step_phase = arr_ph;
                end else if (ch == CH_CLASS) begin
                    step_phase = cls_ph;
                end else if (prim_letter(ch)) begin
                    step_phase = end_ph;
                end
            end
            PH_PARAM_NAME, PH_TAIL_NAME: begin
                if (ch == CH_SEMI) begin
                    step_phase = end_ph;
                end else if (ch != CH_NUL && ch != CH_DOT && ch != CH_LBRACK) begin
                    step_phase = ph;
                end
            end
            default: step_phase = PH_ERROR;
        endcase
    endfunction

    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            grammar_ph   = PH_START;
            opened_paren = 1'b0;
            verdict_q.delete();
        end else begin
            // verdict beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("verdict beat with none expected, m_tdata=%h", m_tdata);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want.valid_res) begin
                        $error("valid_res: expected %0b, actual %0b", want.valid_res,
                               m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[1] !== want.method_kind) begin
                        $error("method_kind: expected %0b, actual %0b", want.method_kind,
                               m_tdata[1]);
                        fail_count++;
                    end
                    if (m_tdata[7:2] !== 6'd0) begin
                        $error("tdata padding: expected %0h, actual %0h", 6'd0, m_tdata[7:2]);
                        fail_count++;
                    end
                end
            end
            // byte beat advances the grammar, final byte yields a verdict
            if (s_tvalid && s_tready) begin
                if (grammar_ph == PH_START && s_tdata == CH_LPAREN) begin
                    opened_paren = 1'b1;
                end
                grammar_ph = step_phase(grammar_ph, s_tdata);
                if (s_tlast) begin
                    want.valid_res   = (grammar_ph == PH_DONE);
                    want.method_kind = opened_paren;
                    verdict_q.push_back(want);
                    grammar_ph   = PH_START;
                    opened_paren = 1'b0;
                end
            end
        end
        pending = verdict_q.size();
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for method_descriptor_validator_top, feeding
// descriptor strings byte by byte; depends on mdv_pkg and descriptor_verdict_checker

module tb;
    import mdv_pkg::*;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'd0;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;

    int         fail_count;
    int         pending;
    bit         no_gaps    = 1'b0;
    int         bytes_sent = 0;
    logic [7:0] str_q[$];

    // clock, 2 ns period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    method_descriptor_validator_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    descriptor_verdict_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // reset held at start, released once
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // run time limit
    initial begin
        #200000;
        $display("RESULT: ERROR");
        $finish;
    end

    // one byte beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [7:0] b, input logic fin);
        while (!no_gaps && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_queue();
        for (int i = 0; i < str_q.size(); i++) begin
            send_beat(str_q[i], i == str_q.size() - 1);
        end
        bytes_sent += str_q.size();
    endtask

    task automatic send_text(input string s);
        str_q.delete();
        for (int i = 0; i < s.len(); i++) begin
            str_q.push_back(s[i]);
        end
        send_queue();
    endtask

    // stop offering bytes until every verdict is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // class name byte, mostly letters, never a terminator or a bad byte
    function automatic logic [7:0] name_char();
        logic [7:0] ch;
        if ($urandom_range(0, 1) == 0) begin
            ch = 8'h61 + 8'($urandom_range(0, 25));
        end else begin
            ch = 8'($urandom_range(1, 255));
            while (ch == CH_SEMI || ch == CH_DOT || ch == CH_LBRACK) begin
                ch = 8'($urandom_range(1, 255));
            end
        end
        return ch;
    endfunction

    function automatic logic [7:0] prim_pick();
        case ($urandom_range(0, 8))
            0:       return CH_B;
            1:       return CH_C;
            2:       return CH_D;
            3:       return CH_F;
            4:       return CH_I;
            5:       return CH_J;
            6:       return CH_S;
            7:       return CH_Z;
            default: return CH_V;
        endcase
    endfunction

    // one well formed type, arrays and class names included
    function automatic void add_type();
        int dims;
        int nlen;
        dims = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (dims) str_q.push_back(CH_LBRACK);
        if ($urandom_range(0, 2) == 0) begin
            nlen = $urandom_range(0, 4);
            str_q.push_back(CH_CLASS);
            repeat (nlen) str_q.push_back(name_char());
            str_q.push_back(CH_SEMI);
        end else begin
            str_q.push_back(prim_pick());
        end
    endfunction

    // byte that tends to break the grammar
    function automatic logic [7:0] spoiler();
        case ($urandom_range(0, 7))
            0:       return CH_RPAREN;
            1:       return CH_LBRACK;
            2:       return CH_DOT;
            3:       return CH_NUL;
            4:       return CH_SEMI;
            5:       return CH_CLASS;
            6:       return CH_LPAREN;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly well formed descriptors, some damaged, a few pure noise
    function automatic void build_string();
        int pos;
        int nparams;
        int nnoise;
        str_q.delete();
        if ($urandom_range(0, 19) == 0) begin
            nnoise = $urandom_range(1, 6);
            repeat (nnoise) str_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 1) == 1) begin
                nparams = $urandom_range(0, 3);
                str_q.push_back(CH_LPAREN);
                repeat (nparams) add_type();
                str_q.push_back(CH_RPAREN);
            end
            add_type();
            if ($urandom_range(0, 3) == 0) begin
                pos = $urandom_range(0, str_q.size() - 1);
                case ($urandom_range(0, 3))
                    0: str_q[pos] = 8'($urandom_range(0, 255));
                    1: if (str_q.size() > 1) begin
                        str_q.delete(str_q.size() - 1);
                    end
                    2: str_q.push_back(spoiler());
                    default: str_q.insert(pos, spoiler());
                endcase
            end
        end
    endfunction

    // verdict side: random stalls, one long hold-off, calm stretch
    initial begin : verdict_sink
        int  beats;
        bit  held;
        beats = 0;
        held  = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (m_tvalid && m_tready) begin
                beats++;
            end
            if (!held && beats >= 15) begin
                // long hold-off so final bytes back up into the input
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else begin
                m_tready <= no_gaps || ($urandom_range(0, 99) >= 30);
                @(posedge aclk);
            end
        end
    end

    // byte stimulus and verdict
    initial begin : byte_source
        int n_str;
        n_str = 0;
        while (!aresetn) @(posedge aclk);

        // zero as first byte
        str_q.delete();
        str_q.push_back(CH_NUL);
        send_queue();
        // lone open paren, then missing return type
        send_text("(");
        send_text("()");
        // close paren right after an array bracket
        send_text("([)V");
        // byte after a complete field type
        send_text("II");
        // fault then ignored top byte
        str_q.delete();
        str_q.push_back(CH_DOT);
        str_q.push_back(8'hFF);
        send_queue();
        // empty class name and void parameter
        send_text("(L;V)Z");
        // dot inside a class name
        send_text("L.");
        send_text("[[J");

        while (bytes_sent < 600) begin
            no_gaps = (n_str >= 40 && n_str < 60);
            if (n_str == 80) begin
                wait_drained();
            end
            build_string();
            send_queue();
            n_str++;
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### method_descriptor_validator_top.f
rtl/core/mdv_pkg.sv
rtl/core/method_descriptor_validator_top.sv
tb/sv/descriptor_verdict_checker.sv
tb/sv/tb.sv
